[hdl/pdc_pkg.sv]
// shared types, constants and crc function for the frame checker
`timescale 1ns / 1ps
`default_nettype none
package pdc_pkg;

  localparam int HEADER_BYTES     = 12;
  localparam int CRC_PREFIX_BYTES = 8;
  localparam int HDR_IDX_W        = $clog2(HEADER_BYTES);
  localparam int COUNT_W          = 32;
  localparam int LEN_W            = COUNT_W + 1;

  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  // frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_SIZE     = 3'd2;
  localparam logic [2:0] ST_VERSION  = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  // configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_VERSION = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME_SIZE   = 8'd1;

  localparam logic [15:0] PROTOCOL_VERSION_RESET = 16'd1;
  localparam logic [31:0] MAX_FRAME_SIZE_RESET   = 32'd1048576;

  // queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // one classified byte, as the front hands it to the back
  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 payload;
    logic                 crc_en;
    logic                 hdr_en;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic                 too_short;
    logic [LEN_W-1:0]     len;
  } entry_t;

  // reflected crc-16 over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/pdc_if.sv]
// channel interfaces: received bytes, results, configuration writes
`timescale 1ns / 1ps
`default_nettype none
interface pdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pdc_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic [15:0] command_code;
  modport source (output valid, output payload_byte, output payload_valid,
                  output frame_done, output frame_status, output command_code,
                  input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input frame_done, input frame_status, input command_code,
                output ready);
endinterface

interface pdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/pdc_front.sv]
// front end: byte counter and per-byte classification
`timescale 1ns / 1ps
`default_nettype none
module pdc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  pdc_byte_if.sink             byte_ch,
  input  wire logic            queue_full,
  output pdc_pkg::entry_t      push_entry,
  output logic                 push
);
  import pdc_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               take;

  assign byte_ch.ready = !queue_full;
  assign take          = byte_ch.valid && !queue_full;
  assign push          = take;

  always_comb begin
    push_entry.data      = byte_ch.data_byte;
    push_entry.last      = byte_ch.last_byte;
    push_entry.payload   = count >= COUNT_W'(HEADER_BYTES);
    push_entry.crc_en    = (count < COUNT_W'(CRC_PREFIX_BYTES)) ||
                           (count >= COUNT_W'(HEADER_BYTES));
    push_entry.hdr_en    = count < COUNT_W'(HEADER_BYTES);
    push_entry.hdr_idx   = count[HDR_IDX_W-1:0];
    push_entry.len       = {1'b0, count} + LEN_W'(1);
    push_entry.too_short = push_entry.len < LEN_W'(HEADER_BYTES);
  end

  // saturating count, cleared after the last byte
  always_comb begin
    count_next = count;
    if (take) begin
      if (byte_ch.last_byte) begin
        count_next = '0;
      end else if (count != {COUNT_W{1'b1}}) begin
        count_next = count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

[hdl/pdc_queue.sv]
// short fifo between front and back
`timescale 1ns / 1ps
`default_nettype none
module pdc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pdc_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output pdc_pkg::entry_t      head,
  output logic                 not_empty
);
  import pdc_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full      = fill == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/pdc_back.sv]
// back end: header capture, crc, status and result register
`timescale 1ns / 1ps
`default_nettype none
module pdc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pdc_pkg::entry_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  input  wire logic [15:0]     protocol_version,
  input  wire logic [31:0]     max_frame_size,
  pdc_result_if.source         result_ch
);
  import pdc_pkg::*;

  logic [31:0] header_size;
  logic [15:0] header_command;
  logic [15:0] header_version;
  logic [31:0] header_checksum;
  logic [15:0] crc_value;

  logic [31:0] header_size_next;
  logic [15:0] header_command_next;
  logic [15:0] header_version_next;
  logic [31:0] header_checksum_next;
  logic [15:0] crc_value_next;
  logic [2:0]  status;

  logic        out_valid;
  logic [7:0]  out_payload_byte;
  logic        out_payload_valid;
  logic        out_frame_done;
  logic [2:0]  out_frame_status;
  logic [15:0] out_command_code;

  // take the next byte whenever the result register is free or draining
  assign pop = head_valid && (!out_valid || result_ch.ready);

  always_comb begin
    header_size_next     = header_size;
    header_command_next  = header_command;
    header_version_next  = header_version;
    header_checksum_next = header_checksum;
    if (head.hdr_en) begin
      unique case (head.hdr_idx)
        4'd0:    header_size_next[31:24]     = head.data;
        4'd1:    header_size_next[23:16]     = head.data;
        4'd2:    header_size_next[15:8]      = head.data;
        4'd3:    header_size_next[7:0]       = head.data;
        4'd4:    header_command_next[15:8]   = head.data;
        4'd5:    header_command_next[7:0]    = head.data;
        4'd6:    header_version_next[15:8]   = head.data;
        4'd7:    header_version_next[7:0]    = head.data;
        4'd8:    header_checksum_next[31:24] = head.data;
        4'd9:    header_checksum_next[23:16] = head.data;
        4'd10:   header_checksum_next[15:8]  = head.data;
        4'd11:   header_checksum_next[7:0]   = head.data;
        default: ;
      endcase
    end
    crc_value_next = head.crc_en ? crc_byte(crc_value, head.data) : crc_value;
  end

  // checks in priority order
  always_comb begin
    priority if (head.too_short) begin
      status = ST_SHORT;
    end else if ((header_size_next > max_frame_size) ||
                 ({1'b0, header_size_next} != head.len)) begin
      status = ST_SIZE;
    end else if (header_version_next != protocol_version) begin
      status = ST_VERSION;
    end else if (header_checksum_next != {16'h0000, crc_value_next ^ CRC_XOROUT}) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_size     <= '0;
      header_command  <= '0;
      header_version  <= '0;
      header_checksum <= '0;
      crc_value       <= CRC_INIT;
    end else if (pop) begin
      if (head.last) begin
        header_size     <= '0;
        header_command  <= '0;
        header_version  <= '0;
        header_checksum <= '0;
        crc_value       <= CRC_INIT;
      end else begin
        header_size     <= header_size_next;
        header_command  <= header_command_next;
        header_version  <= header_version_next;
        header_checksum <= header_checksum_next;
        crc_value       <= crc_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_payload_byte  <= head.payload ? head.data : 8'h00;
      out_payload_valid <= head.payload;
      out_frame_done    <= head.last;
      out_frame_status  <= head.last ? status : ST_OK;
      out_command_code  <= head.last ? header_command_next : 16'h0000;
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.payload_byte  = out_payload_byte;
  assign result_ch.payload_valid = out_payload_valid;
  assign result_ch.frame_done    = out_frame_done;
  assign result_ch.frame_status  = out_frame_status;
  assign result_ch.command_code  = out_command_code;

endmodule
`default_nettype wire

[hdl/packet_deframer_crc16_check.sv]
// top level of the length-prefixed frame checker with crc-16/x-25
//
// usage:
//   byte_ch   : one received frame byte per request, last_byte flags the end
//   result_ch : one result per byte; payload_byte/payload_valid for bytes at
//               offset 12 and up, frame_done with frame_status and
//               command_code on the last byte of a frame
//   cfg_ch    : register writes, index 0 protocol_version, index 1
//               max_frame_size; other indexes are ignored; always ready
// throughput: one byte per cycle while result_ch is ready, set by the
//   byte-wide crc update in the back end; front counter and back end are
//   split by a four-entry queue, and the result register drives result_ch
// reset (synchronous, active high) empties the queue and the result
//   register, clears the frame state and loads the register defaults
// when result_ch stalls the result register holds, the queue fills and
//   byte_ch.ready drops once it is full; nothing is lost or repeated
// user writes configuration only while no frame byte is in flight; unchecked
`timescale 1ns / 1ps
`default_nettype none
module packet_deframer_crc16_check (
  input  wire logic     clk,
  input  wire logic     rst,
  pdc_byte_if.sink      byte_ch,
  pdc_result_if.source  result_ch,
  pdc_cfg_if.sink       cfg_ch
);
  import pdc_pkg::*;

  // configuration registers
  logic [15:0] protocol_version;
  logic [31:0] max_frame_size;

  // front to queue
  entry_t push_entry;
  logic   push;
  logic   queue_full;

  // queue to back
  entry_t head;
  logic   head_valid;
  logic   pop;

  // register writes taken every cycle; version keeps only the low 16 bits
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= PROTOCOL_VERSION_RESET;
      max_frame_size   <= MAX_FRAME_SIZE_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_PROTOCOL_VERSION) begin
        protocol_version <= cfg_ch.data[15:0];
      end else if (cfg_ch.index == REG_MAX_FRAME_SIZE) begin
        max_frame_size <= cfg_ch.data;
      end
    end
  end

  // counts bytes and tags each one with its role in the frame
  pdc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .queue_full (queue_full),
    .push_entry (push_entry),
    .push       (push)
  );

  // lets the front keep taking bytes while the back waits on the receiver
  pdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .not_empty  (head_valid)
  );

  // header capture, crc, checks and the result register
  pdc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop),
    .protocol_version (protocol_version),
    .max_frame_size   (max_frame_size),
    .result_ch        (result_ch)
  );

endmodule
`default_nettype wire

[tb/tb_packet_deframer_crc16_check.sv]
// self-checking testbench for the length-prefixed frame checker with crc-16/x-25
`timescale 1ns / 1ps
module tb_packet_deframer_crc16_check;
  import pdc_pkg::*;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no request moving on any channel
  localparam int SETTLE_CYCLES = 4;     // idle margin after the last result, before registers change
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hA5;

  // one received byte as the sender presents it
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } rx_byte_t;

  // one result request as the checker should return it
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [2:0]  frame_status;
    logic [15:0] command_code;
  } frame_result_t;

  typedef enum int {
    FR_GOOD, FR_BAD_VERSION, FR_BAD_CHECKSUM, FR_BAD_SIZE, FR_SHORT, FR_NOISE
  } frame_kind_t;

  typedef enum int {SINK_FREE, SINK_COIN, SINK_COMB, SINK_BURSTY} sink_mode_t;

  logic clk;
  logic rst;

  pdc_byte_if   byte_ch ();
  pdc_result_if result_ch ();
  pdc_cfg_if    cfg_ch ();

  packet_deframer_crc16_check dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .cfg_ch    (cfg_ch)
  );

  // bytes waiting to be sent, results the checker still owes us
  rx_byte_t      pending_bytes[$];
  frame_result_t expected_results[$];
  int            mismatches;

  // mirror of the checker: registers and per-frame state
  logic [15:0] cfg_version;
  logic [31:0] cfg_max_size;
  logic [31:0] rx_count;
  logic [15:0] crc_acc;
  logic [31:0] hdr_size;
  logic [15:0] hdr_cmd;
  logic [15:0] hdr_ver;
  logic [31:0] hdr_csum;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // crc-16/x-25 register update, one bit at a time, lsb first
  function automatic logic [15:0] crc16_x25_step(logic [15:0] acc, logic [7:0] value);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ value[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic void clear_frame_state();
    rx_count = '0;
    crc_acc  = CRC_INIT;
    hdr_size = '0;
    hdr_cmd  = '0;
    hdr_ver  = '0;
    hdr_csum = '0;
  endfunction

  // advance the mirrored state by one accepted byte and return what it must produce
  function automatic frame_result_t predict_result(rx_byte_t item);
    frame_result_t res;
    logic [31:0]   offset;
    logic [32:0]   frame_len;
    logic [15:0]   crc_final;
    logic          in_payload;
    res        = '0;
    offset     = rx_count;
    in_payload = (offset >= HEADER_BYTES);
    // big-endian header: size, command, version, checksum
    unique case (offset)
      0:  hdr_size[31:24] = item.data;
      1:  hdr_size[23:16] = item.data;
      2:  hdr_size[15:8]  = item.data;
      3:  hdr_size[7:0]   = item.data;
      4:  hdr_cmd[15:8]   = item.data;
      5:  hdr_cmd[7:0]    = item.data;
      6:  hdr_ver[15:8]   = item.data;
      7:  hdr_ver[7:0]    = item.data;
      8:  hdr_csum[31:24] = item.data;
      9:  hdr_csum[23:16] = item.data;
      10: hdr_csum[15:8]  = item.data;
      11: hdr_csum[7:0]   = item.data;
      default: ;
    endcase
    // checksum bytes themselves are skipped by the crc
    if (offset < CRC_PREFIX_BYTES || in_payload) crc_acc = crc16_x25_step(crc_acc, item.data);
    if (rx_count != 32'hFFFF_FFFF) rx_count = rx_count + 32'd1;
    if (item.eof) begin
      frame_len = {1'b0, offset} + 33'd1;
      crc_final = crc_acc ^ CRC_XOROUT;
      if (frame_len < HEADER_BYTES) begin
        res.frame_status = ST_SHORT;
      end else if (hdr_size > cfg_max_size || {1'b0, hdr_size} != frame_len) begin
        res.frame_status = ST_SIZE;
      end else if (hdr_ver != cfg_version) begin
        res.frame_status = ST_VERSION;
      end else if (hdr_csum != {16'h0000, crc_final}) begin
        res.frame_status = ST_CHECKSUM;
      end else begin
        res.frame_status = ST_OK;
      end
      res.frame_done   = 1'b1;
      res.command_code = hdr_cmd;
      clear_frame_state();
    end
    if (in_payload) begin
      res.payload_valid = 1'b1;
      res.payload_byte  = item.data;
    end
    return res;
  endfunction

  function automatic void push_byte(logic [7:0] value, logic is_eof);
    pending_bytes.push_back(rx_byte_t'{data: value, eof: is_eof});
  endfunction

  // build one frame of the given kind against the current register values
  function automatic int queue_frame(frame_kind_t kind, int payload_len, logic [15:0] cmd);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  payload[$];
    logic [15:0] crc;
    logic [15:0] ver;
    logic [31:0] size;
    logic [31:0] csum;
    int          keep;
    ver  = cfg_version;
    size = HEADER_BYTES + payload_len;
    if (kind == FR_BAD_VERSION) ver ^= 16'(1 << $urandom_range(0, 15));
    if (kind == FR_BAD_SIZE) begin
      case ($urandom_range(0, 2))
        0:       size = size + 32'd1;
        1:       size = size - 32'd1;
        default: size = $urandom;
      endcase
    end
    frame_bytes = {size[31:24], size[23:16], size[15:8], size[7:0],
                   cmd[15:8], cmd[7:0], ver[15:8], ver[7:0]};
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = crc16_x25_step(crc, frame_bytes[i]);
    repeat (payload_len) payload.push_back(8'($urandom));
    foreach (payload[i]) crc = crc16_x25_step(crc, payload[i]);
    csum = {16'h0000, crc ^ CRC_XOROUT};
    // a flipped bit anywhere, the zero upper half included
    if (kind == FR_BAD_CHECKSUM) csum ^= 32'h1 << $urandom_range(0, 31);
    frame_bytes.push_back(csum[31:24]);
    frame_bytes.push_back(csum[23:16]);
    frame_bytes.push_back(csum[15:8]);
    frame_bytes.push_back(csum[7:0]);
    foreach (payload[i]) frame_bytes.push_back(payload[i]);
    if (kind == FR_SHORT) begin
      keep = $urandom_range(1, HEADER_BYTES - 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
    if (kind == FR_NOISE) begin
      frame_bytes = {};
      repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
    end
    foreach (frame_bytes[i]) push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    return frame_bytes.size();
  endfunction

  // about half well-formed frames, the rest broken in one way each
  function automatic void queue_random_frames(int byte_budget);
    int          queued;
    int          pick;
    int          plen;
    frame_kind_t kind;
    queued = 0;
    while (queued < byte_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = FR_GOOD;
      else if (pick < 60) kind = FR_BAD_VERSION;
      else if (pick < 72) kind = FR_BAD_CHECKSUM;
      else if (pick < 82) kind = FR_BAD_SIZE;
      else if (pick < 92) kind = FR_SHORT;
      else kind = FR_NOISE;
      plen = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 20);
      queued += queue_frame(kind, plen, 16'($urandom));
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    // the write request is taken at this edge
    unique case (idx)
      REG_PROTOCOL_VERSION: cfg_version  = value[15:0];
      REG_MAX_FRAME_SIZE:   cfg_max_size = value;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // registers may only change once every byte in flight has come back
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // byte sender: bursts of random length, random gaps, and a full drain every
  // few frames so the checker is seen restarting from an empty pipeline
  // ---------------------------------------------------------------------------
  int   gap_left;
  int   burst_left;
  int   frames_sent;
  logic drain_hold;

  always @(posedge clk) begin : drive_bytes
    rx_byte_t sent;
    logic     accepted;
    logic     present;
    if (rst) begin
      byte_ch.valid <= 1'b0;
      gap_left    = 0;
      burst_left  = $urandom_range(1, 24);
      frames_sent = 0;
      drain_hold  = 1'b0;
    end else begin
      accepted = byte_ch.valid && byte_ch.ready;
      if (accepted) begin
        sent = pending_bytes.pop_front();
        expected_results.push_back(predict_result(sent));
        if (sent.eof) begin
          frames_sent++;
          if (frames_sent % 7 == 3) drain_hold = 1'b1;
        end
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
      // a request once offered stays until it is taken
      if (byte_ch.valid && !accepted) begin
        present = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        present = 1'b0;
      end else begin
        present = !drain_hold && pending_bytes.size() != 0;
      end
      byte_ch.valid <= present;
      if (present) begin
        byte_ch.data_byte <= pending_bytes[0].data;
        byte_ch.last_byte <= pending_bytes[0].eof;
      end else begin
        byte_ch.data_byte <= 8'($urandom);
        byte_ch.last_byte <= 1'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: compares each request with the oldest prediction and
  // stalls on a pattern whose mode is redrawn at random from four
  // ---------------------------------------------------------------------------
  sink_mode_t sink_mode;
  int         mode_left;
  int         run_left;
  int         sink_tick;
  logic       run_ready;

  always @(posedge clk) begin : check_results
    frame_result_t want;
    logic          ready_next;
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_mode = SINK_FREE;
      mode_left = 0;
      run_left  = 0;
      sink_tick = 0;
      run_ready = 1'b1;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: payload_byte 0x%0h frame_done %0b",
                 result_ch.payload_byte, result_ch.frame_done);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("payload_byte", 32'(want.payload_byte), 32'(result_ch.payload_byte));
          check_field("payload_valid", 32'(want.payload_valid),
                      32'(result_ch.payload_valid));
          check_field("frame_done", 32'(want.frame_done), 32'(result_ch.frame_done));
          check_field("frame_status", 32'(want.frame_status), 32'(result_ch.frame_status));
          check_field("command_code", 32'(want.command_code), 32'(result_ch.command_code));
        end
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 200);
      end else begin
        mode_left--;
      end
      sink_tick++;
      unique case (sink_mode)
        SINK_FREE: ready_next = 1'b1;
        SINK_COIN: ready_next = 1'($urandom);
        SINK_COMB: ready_next = (sink_tick % 4) != 3;
        default: begin
          // long runs of stall and of flow
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left  = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 16);
          end else begin
            run_left--;
          end
          ready_next = run_ready;
        end
      endcase
      result_ch.ready <= ready_next;
    end
  end

  // watchdog: no request moving on any channel for too long ends the run
  int idle_cycles;

  always @(posedge clk) begin : watchdog
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("packet_deframer_crc16_check: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // phases: each runs under one register setting, with a full drain between
  // ---------------------------------------------------------------------------
  initial begin : run_test
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_PROTOCOL_VERSION;
    cfg_ch.data       = '0;
    mismatches        = 0;
    cfg_version       = PROTOCOL_VERSION_RESET;
    cfg_max_size      = MAX_FRAME_SIZE_RESET;
    clear_frame_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values; single-byte frame, a frame cut off right after
    // the first command byte, and a header-only frame that passes
    push_byte(8'hFF, 1'b1);
    repeat (4) push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    void'(queue_frame(FR_GOOD, 0, 16'hFFFF));
    queue_random_frames(100);
    wait_drained();

    // upper extremes; upper data bits of the version write must be dropped
    write_register(REG_PROTOCOL_VERSION, 32'hFFFF_FFFF);
    write_register(REG_MAX_FRAME_SIZE, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_random_frames(110);
    wait_drained();

    // lower extremes: only header-only frames can fit
    write_register(REG_PROTOCOL_VERSION, 32'hFFFF_0000);
    write_register(REG_MAX_FRAME_SIZE, HEADER_BYTES);
    @(negedge clk);
    queue_random_frames(110);
    wait_drained();

    // tight size limit so oversize frames with a correct length show up;
    // a write to an unmapped index must change nothing
    write_register(REG_PROTOCOL_VERSION, $urandom);
    write_register(REG_MAX_FRAME_SIZE, $urandom_range(HEADER_BYTES, 48));
    write_register(REG_UNMAPPED, $urandom);
    @(negedge clk);
    queue_random_frames(110);
    wait_drained();

    write_register(REG_MAX_FRAME_SIZE, $urandom_range(100, 32'h7FFF_FFFF));
    write_register(REG_PROTOCOL_VERSION, $urandom);
    @(negedge clk);
    queue_random_frames(120);
    wait_drained();

    if (mismatches == 0) begin
      $display("packet_deframer_crc16_check: match");
    end else begin
      $display("packet_deframer_crc16_check: mismatch");
    end
    $finish;
  end

endmodule
